// ===== rtl/per_rank_version_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// per-rank version table assertion macros
// shared concurrent assertion forms, sampled on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef PER_RANK_VERSION_TABLE_CORE_DEFINES_SVH
`define PER_RANK_VERSION_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define PRVT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// next-cycle implication
`define PRVT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

// ===== rtl/prvt_pkg.sv =====
// ----------------------------------------------------------------------------
// prvt_pkg
// command and result codes, register map and control types of the version table
// ----------------------------------------------------------------------------
package prvt_pkg;

	localparam logic [2:0] CMD_READ    = 3'd0;
	localparam logic [2:0] CMD_WRITE   = 3'd1;
	localparam logic [2:0] CMD_ADVANCE = 3'd2;
	localparam logic [2:0] CMD_DUMP    = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	localparam logic [2:0] KIND_READ    = 3'd0;
	localparam logic [2:0] KIND_ADVANCE = 3'd1;
	localparam logic [2:0] KIND_ACK     = 3'd2;
	localparam logic [2:0] KIND_ENTRY   = 3'd3;
	localparam logic [2:0] KIND_END     = 3'd4;

	// register index taken from paddr[2]
	localparam logic       REG_RANKS_IN_USE = 1'b0;
	localparam logic [5:0] RANKS_RESET      = 6'd32;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic dump_chk;
		logic dump_end;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic ptr_end;
	} sts_t;

endpackage

// ===== rtl/per_rank_version_table_core.sv =====
// read, write, advance and clear: accepted into the exec state, result strobed from the result register
// busy holds off the next of these until the exec state, with the slot read data and write-back, ends
// dump: one memory read and one check per rank in use, then an end result
// results are strobed for one cycle on done; the receiver cannot stall
// async reset zeroes all slots through their valid bits, ranks_in_use resets to 32
// ----------------------------------------------------------------------------
// per_rank_version_table_core
// top level: apb register, sequencer and slot datapath
// ----------------------------------------------------------------------------
module per_rank_version_table_core #(
	parameter int NRANKS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [5:0]  rank,
	input  logic [63:0] value,
	output logic        done,
	output logic [2:0]  kind,
	output logic [4:0]  rank_out,
	output logic [63:0] value_out,
	output logic        advanced,
	output logic [5:0]  entry_count,
	output logic        last
);
	import prvt_pkg::*;

	logic [5:0] ranks_q;
	logic       sel_ranks;
	ctl_t       ctl;
	sts_t       sts;

	assign pready    = 1'b1;
	assign sel_ranks = paddr[2] == REG_RANKS_IN_USE;
	assign prdata    = sel_ranks ? {26'd0, ranks_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ranks_q <= RANKS_RESET;
		end else if (psel && penable && pwrite && pready && sel_ranks) begin
			ranks_q <= pwdata[5:0];
		end
	end

	prvt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy)
	);

	prvt_dp #(
		.NRANKS (NRANKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.command      (command),
		.rank         (rank),
		.value        (value),
		.ranks_in_use (ranks_q),
		.done         (done),
		.kind         (kind),
		.rank_out     (rank_out),
		.value_out    (value_out),
		.advanced     (advanced),
		.entry_count  (entry_count),
		.last         (last)
	);

endmodule

// ===== rtl/prvt_dp.sv =====
// ----------------------------------------------------------------------------
// prvt_dp
// slot memory with valid bits, command registers, compare and result registers
// ----------------------------------------------------------------------------
module prvt_dp #(
	parameter int NRANKS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  prvt_pkg::ctl_t     ctl,
	output prvt_pkg::sts_t     sts,
	input  logic [2:0]         command,
	input  logic [5:0]         rank,
	input  logic [63:0]        value,
	input  logic [5:0]         ranks_in_use,
	output logic               done,
	output logic [2:0]         kind,
	output logic [4:0]         rank_out,
	output logic [63:0]        value_out,
	output logic               advanced,
	output logic [5:0]         entry_count,
	output logic               last
);
	import prvt_pkg::*;

	localparam int         AW = (NRANKS > 1) ? $clog2(NRANKS) : 1;
	localparam logic [5:0] NR = 6'(NRANKS);

	logic [63:0]       slots_q [NRANKS];
	logic [NRANKS-1:0] vld_q;
	logic [63:0]       rd_q;
	logic              rdv_q;

	logic [2:0]        cmd_q;
	logic [AW-1:0]     idx_q;
	logic              ok_q;
	logic [63:0]       value_q;
	logic [5:0]        n_q;
	logic [5:0]        ptr_q;
	logic [5:0]        cnt_q;
	logic              done_q;

	logic [5:0]        n_eff;
	logic              ok_in;
	logic [AW-1:0]     rd_addr;
	logic [63:0]       slot;
	logic              hit;
	logic              gt;
	logic              wr_en;
	logic              emit;
	logic [2:0]        o_kind;
	logic [4:0]        o_rank;
	logic [63:0]       o_val;
	logic              o_adv;
	logic [5:0]        o_cnt;
	logic              o_last;

	// effective rank count saturates at the table depth
	assign n_eff = (ranks_in_use > NR) ? NR : ranks_in_use;
	assign ok_in = rank < n_eff;
	assign sts.ptr_end = ptr_q >= n_q;

	always_comb begin
		if (ctl.load) begin
			rd_addr = ok_in ? rank[AW-1:0] : '0;
		end else begin
			rd_addr = sts.ptr_end ? '0 : ptr_q[AW-1:0];
		end
	end

	// a slot never written since the last clear reads as zero
	assign slot  = rdv_q ? rd_q : 64'd0;
	assign hit   = slot != 64'd0;
	assign gt    = value_q > slot;
	assign wr_en = ctl.exec && ok_q &&
		((cmd_q == CMD_WRITE) || ((cmd_q == CMD_ADVANCE) && gt));

	always_ff @(posedge clk) begin
		rd_q  <= slots_q[rd_addr];
		rdv_q <= vld_q[rd_addr];
		if (wr_en) begin
			slots_q[idx_q] <= value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.exec && (cmd_q == CMD_CLEAR)) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= command;
			idx_q   <= rank[AW-1:0];
			ok_q    <= ok_in;
			value_q <= value;
			n_q     <= n_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
		end else if (ctl.load) begin
			ptr_q <= '0;
			if (command == CMD_DUMP) begin
				cnt_q <= '0;
			end
		end else if (ctl.dump_chk) begin
			ptr_q <= ptr_q + 6'd1;
			if (hit) begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_comb begin
		emit   = 1'b0;
		o_kind = KIND_ACK;
		o_rank = '0;
		o_val  = '0;
		o_adv  = 1'b0;
		o_cnt  = '0;
		o_last = 1'b1;
		if (ctl.exec) begin
			emit = 1'b1;
			case (cmd_q)
				CMD_READ: begin
					o_kind = KIND_READ;
					o_val  = ok_q ? slot : 64'd0;
				end
				CMD_ADVANCE: begin
					o_kind = KIND_ADVANCE;
					o_adv  = ok_q && gt;
				end
				default: begin
					o_kind = KIND_ACK;
				end
			endcase
		end else if (ctl.dump_chk) begin
			emit   = hit;
			o_kind = KIND_ENTRY;
			o_rank = ptr_q[4:0];
			o_val  = slot;
			o_last = 1'b0;
		end else if (ctl.dump_end) begin
			emit   = 1'b1;
			o_kind = KIND_END;
			o_cnt  = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind        <= o_kind;
			rank_out    <= o_rank;
			value_out   <= o_val;
			advanced    <= o_adv;
			entry_count <= o_cnt;
			last        <= o_last;
		end
	end

	assign done = done_q;

endmodule

// ===== rtl/prvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// prvt_ctrl
// command sequencer: single access or dump walk over the ranks in use
// ----------------------------------------------------------------------------
module prvt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2:0]     command,
	input  prvt_pkg::sts_t sts,
	output prvt_pkg::ctl_t ctl,
	output logic           busy
);
	import prvt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_DRD  = 5'b00100,
		S_DCHK = 5'b01000,
		S_DEND = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;
	logic   known_cmd;

	assign busy      = state_q != S_IDLE;
	assign accept    = start && !busy;
	// unused command codes are taken and dropped
	assign known_cmd = command <= CMD_CLEAR;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && known_cmd) begin
					state_d = (command == CMD_DUMP) ? S_DRD : S_EXEC;
				end
			end
			S_EXEC: state_d = S_IDLE;
			S_DRD:  state_d = sts.ptr_end ? S_DEND : S_DCHK;
			S_DCHK: state_d = S_DRD;
			S_DEND: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ctl.load     = accept && known_cmd;
	assign ctl.exec     = state_q == S_EXEC;
	assign ctl.dump_chk = state_q == S_DCHK;
	assign ctl.dump_end = state_q == S_DEND;

endmodule

// ===== rtl/prvt_checker.sv =====
// ----------------------------------------------------------------------------
// prvt_checker
// port-level checks of command sequencing and result framing
// ----------------------------------------------------------------------------
`include "per_rank_version_table_core_defines.svh"

module prvt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] command,
	input logic       done,
	input logic [2:0] kind,
	input logic       last
);
	import prvt_pkg::*;

	// a known command holds off the next transaction
	`PRVT_ASSERT_NXT(a_busy_after_cmd, start && !busy && (command == CMD_READ || command == CMD_WRITE || command == CMD_ADVANCE || command == CMD_DUMP || command == CMD_CLEAR), busy, "known command did not raise busy")

	// single-result commands answer with a final result, through the exec state and the result register
	`PRVT_ASSERT_IMP(a_single_latency, start && !busy && (command == CMD_READ || command == CMD_WRITE || command == CMD_ADVANCE || command == CMD_CLEAR), ##2 (done && last), "single result missing or late")

	// dump entries are never final
	`PRVT_ASSERT_IMP(a_entry_not_last, done && (kind == KIND_ENTRY), !last, "dump entry flagged last")

	// the final result frees the block
	`PRVT_ASSERT_IMP(a_last_frees, done && last, !busy, "busy after final result")

endmodule

bind per_rank_version_table_core prvt_checker u_prvt_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the per-rank version table: commands go in through
// start/busy, every strobed result is checked field by field against a
// shadow of the slot table, across several rank-count settings set over apb
// ----------------------------------------------------------------------------
module tb;
	import prvt_pkg::*;

	localparam int NRANKS = 32;
	localparam int SETTLE_CYCLES = 2 * NRANKS + 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 34;
	localparam int NUM_PHASES = 7;
	localparam logic [2:0] RANKS_ADDR = {REG_RANKS_IN_USE, 2'b00};
	localparam logic [2:0] SPARE_ADDR = {~REG_RANKS_IN_USE, 2'b00};

	typedef struct packed {
		logic [2:0]  cmd;
		logic [5:0]  rk;
		logic [63:0] val;
	} table_cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  rank_out;
		logic [63:0] value_out;
		logic        advanced;
		logic [5:0]  entry_count;
		logic        last;
	} table_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  command = CMD_READ;
	logic [5:0]  rank = '0;
	logic [63:0] value = '0;
	logic        done;
	logic [2:0]  kind;
	logic [4:0]  rank_out;
	logic [63:0] value_out;
	logic        advanced;
	logic [5:0]  entry_count;
	logic        last;

	table_cmd_t   pending_cmds[$];
	table_reply_t want_replies[$];
	logic [63:0]  shadow_ver[NRANKS];
	logic [5:0]   shadow_ranks = RANKS_RESET;

	logic       cmd_took = 1'b0;
	logic       quiet_run = 1'b0;
	int         gap_left = 0;
	int         idle_cycles = 0;
	int         mismatches = 0;
	int         n_cmds = 0;
	int         n_replies = 0;
	int         n_dump_entries = 0;
	int         n_adv_taken = 0;
	table_cmd_t next_cmd;
	table_reply_t head;
	logic [5:0] phase_ranks[NUM_PHASES];

	per_rank_version_table_core #(
		.NRANKS(NRANKS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.command(command),
		.rank(rank),
		.value(value),
		.done(done),
		.kind(kind),
		.rank_out(rank_out),
		.value_out(value_out),
		.advanced(advanced),
		.entry_count(entry_count),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [5:0] active_limit(logic [5:0] n);
		return (n > NRANKS) ? 6'(NRANKS) : n;
	endfunction

	function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
	endfunction

	function automatic void queue_reply(logic [2:0] k, logic [4:0] rko, logic [63:0] vo,
			logic adv, logic [5:0] cnt, logic lst);
		table_reply_t r;
		r = '{k, rko, vo, adv, cnt, lst};
		want_replies.push_back(r);
	endfunction

	// updates the shadow table and queues what the block must answer
	function automatic void predict_replies(table_cmd_t c);
		logic [5:0] lim;
		logic       hit;
		logic       took_adv;
		logic [5:0] found;
		lim = active_limit(shadow_ranks);
		hit = c.rk < lim;
		took_adv = 1'b0;
		found = '0;
		case (c.cmd)
			CMD_READ: begin
				queue_reply(KIND_READ, '0, hit ? shadow_ver[c.rk[4:0]] : 64'd0, 1'b0, '0, 1'b1);
			end
			CMD_WRITE: begin
				if (hit)
					shadow_ver[c.rk[4:0]] = c.val;
				queue_reply(KIND_ACK, '0, '0, 1'b0, '0, 1'b1);
			end
			CMD_ADVANCE: begin
				if (hit && c.val > shadow_ver[c.rk[4:0]]) begin
					shadow_ver[c.rk[4:0]] = c.val;
					took_adv = 1'b1;
					n_adv_taken++;
				end
				queue_reply(KIND_ADVANCE, '0, '0, took_adv, '0, 1'b1);
			end
			CMD_DUMP: begin
				for (int r = 0; r < lim; r++) begin
					if (shadow_ver[r] != 0) begin
						queue_reply(KIND_ENTRY, 5'(r), shadow_ver[r], 1'b0, '0, 1'b0);
						found++;
						n_dump_entries++;
					end
				end
				queue_reply(KIND_END, '0, '0, 1'b0, found, 1'b1);
			end
			CMD_CLEAR: begin
				for (int r = 0; r < NRANKS; r++)
					shadow_ver[r] = '0;
				queue_reply(KIND_ACK, '0, '0, 1'b0, '0, 1'b1);
			end
			default: begin
				// unused codes: no result
			end
		endcase
	endfunction

	// driver: holds a command until it is taken, then waits its drawn gap
	always @(negedge clk) begin
		if (arst_n && !(start && !cmd_took)) begin
			if (gap_left != 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() != 0) begin
				next_cmd = pending_cmds.pop_front();
				start <= 1'b1;
				command <= next_cmd.cmd;
				rank <= next_cmd.rk;
				value <= next_cmd.val;
				if ($urandom_range(0, 15) == 0)
					quiet_run = !quiet_run;
				gap_left <= quiet_run ? 0 : $urandom_range(0, 4);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: checks results, predicts accepted commands, tracks the register
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_took <= 1'b0;
		end else begin
			cmd_took <= start && !busy;
			if (done) begin
				n_replies++;
				if (want_replies.size() == 0) begin
					flag_mismatch("unexpected result, kind", '0, 64'(kind));
				end else begin
					head = want_replies.pop_front();
					if (kind !== head.kind)
						flag_mismatch("kind", 64'(head.kind), 64'(kind));
					if (rank_out !== head.rank_out)
						flag_mismatch("rank_out", 64'(head.rank_out), 64'(rank_out));
					if (value_out !== head.value_out)
						flag_mismatch("value_out", head.value_out, value_out);
					if (advanced !== head.advanced)
						flag_mismatch("advanced", 64'(head.advanced), 64'(advanced));
					if (entry_count !== head.entry_count)
						flag_mismatch("entry_count", 64'(head.entry_count),
							64'(entry_count));
					if (last !== head.last)
						flag_mismatch("last", 64'(head.last), 64'(last));
				end
			end
			if (start && !busy) begin
				n_cmds++;
				predict_replies({command, rank, value});
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_RANKS_IN_USE)
				shadow_ranks = pwdata[5:0];
			if ((start && !busy) || done || (psel && penable)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
					$display("tb failed");
					$finish;
				end
			end
		end
	end

	task automatic add_cmd(logic [2:0] c, logic [5:0] rk, logic [63:0] val);
		table_cmd_t t;
		t = '{c, rk, val};
		pending_cmds.push_back(t);
	endtask

	task automatic add_random_cmd();
		logic [5:0]  lim;
		logic [2:0]  c;
		logic [5:0]  rk;
		logic [63:0] val;
		int          pick;
		lim = active_limit(shadow_ranks);
		pick = $urandom_range(0, 99);
		if (pick < 26)
			c = CMD_READ;
		else if (pick < 52)
			c = CMD_WRITE;
		else if (pick < 80)
			c = CMD_ADVANCE;
		else if (pick < 89)
			c = CMD_DUMP;
		else if (pick < 93)
			c = CMD_CLEAR;
		else
			c = CMD_CLEAR + 3'($urandom_range(1, 3));
		if (lim != 0 && $urandom_range(0, 99) < 85)
			rk = 6'($urandom_range(0, lim - 1));
		else
			rk = 6'($urandom_range(0, 63));
		// small values make advances collide with stored versions
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: val = 64'($urandom_range(0, 15));
			6, 7: val = {$urandom(), $urandom()};
			8: val = '1;
			default: val = 64'd1 << $urandom_range(0, 63);
		endcase
		add_cmd(c, rk, val);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_ranks_reg();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= RANKS_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {26'd0, shadow_ranks})
			flag_mismatch("ranks_in_use readback", {58'd0, shadow_ranks}, 64'(prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// sampled at posedge so a command still waiting on busy keeps us here
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || start || want_replies.size() != 0);
	endtask

	initial begin
		for (int i = 0; i < NRANKS; i++)
			shadow_ver[i] = '0;
		phase_ranks = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd17, 6'd5, 6'd32};
		phase_ranks[5] = 6'($urandom_range(2, 30));
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		check_ranks_reg();

		// directed: empty dump, extremes of rank and value, advance edges
		add_cmd(CMD_DUMP, 6'd0, '0);
		add_cmd(CMD_READ, 6'd0, '1);
		add_cmd(CMD_WRITE, 6'd0, '1);
		add_cmd(CMD_WRITE, 6'd31, 64'd1);
		add_cmd(CMD_WRITE, 6'd32, 64'd5);
		add_cmd(CMD_WRITE, 6'd63, 64'hA5A5_5A5A_0F0F_F0F0);
		add_cmd(CMD_READ, 6'd31, '0);
		add_cmd(CMD_READ, 6'd32, '0);
		add_cmd(CMD_READ, 6'd63, '0);
		add_cmd(CMD_ADVANCE, 6'd31, 64'd1);
		add_cmd(CMD_ADVANCE, 6'd31, 64'd2);
		add_cmd(CMD_ADVANCE, 6'd0, '1);
		add_cmd(CMD_ADVANCE, 6'd40, 64'd7);
		add_cmd(CMD_ADVANCE, 6'd5, 64'd0);
		add_cmd(CMD_WRITE, 6'd5, 64'h8000_0000_0000_0000);
		add_cmd(CMD_DUMP, 6'd63, '1);
		add_cmd(CMD_CLEAR + 3'd1, 6'd1, 64'd9);
		add_cmd(CMD_CLEAR + 3'd2, 6'd2, 64'd9);
		add_cmd(CMD_CLEAR + 3'd3, 6'd3, 64'd9);
		add_cmd(CMD_READ, 6'd5, '0);
		add_cmd(CMD_CLEAR, 6'd0, '0);
		add_cmd(CMD_DUMP, 6'd0, '0);
		add_cmd(CMD_READ, 6'd0, '0);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		for (int p = 0; p < NUM_PHASES; p++) begin
			// upper data bits are junk, only the low six land in the register
			write_reg(RANKS_ADDR, ($urandom() & 32'hFFFF_FFC0) | {26'd0, phase_ranks[p]});
			if (p == 2)
				write_reg(SPARE_ADDR, $urandom());
			check_ranks_reg();
			add_cmd(CMD_DUMP, 6'($urandom_range(0, 63)), {$urandom(), $urandom()});
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				add_random_cmd();
				if (i == ITEMS_PER_PHASE / 2)
					wait_drained();
			end
			wait_drained();
			repeat (SETTLE_CYCLES) @(negedge clk);
		end

		if (want_replies.size() != 0)
			flag_mismatch("results never produced", '0, 64'(want_replies.size()));
		$display("covered %0d commands and %0d results over %0d rank-count settings",
			n_cmds, n_replies, NUM_PHASES + 1);
		$display("%0d dump entries, %0d advances taken, %0d mismatches",
			n_dump_entries, n_adv_taken, mismatches);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
